@@ rtl/stkl_pkg.sv @@
// stkl_pkg: types, codes and constants shared by the sorted top-K list core.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package stkl_pkg;

  // Entry and field widths fixed by the beat format
  localparam int unsigned EntryW        = 32;
  localparam int unsigned CfgIdxW       = 1;
  localparam int unsigned CfgDataW      = 32;
  localparam int unsigned ListDepthDef  = 16;

  // Reset value of every entry and of the fill register
  localparam logic signed [EntryW-1:0] EntryMin = {1'b1, {(EntryW-1){1'b0}}};

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DESCENDING = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_FILL_VALUE = 1'b1;

  // Operation codes
  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_DELETE = 1'b1
  } func_e;

  // Input beat payload
  typedef struct packed {
    func_e                    func;
    logic signed [EntryW-1:0] value;
  } in_beat_t;

  // Output beat payload
  typedef struct packed {
    logic signed [EntryW-1:0] head_entry;
    logic signed [EntryW-1:0] tail_entry;
    logic                     delete_found;
  } out_beat_t;

  // Operation token that travels down the cell chain
  typedef struct packed {
    logic                     tok;    // operation present at this cell
    func_e                    func;
    logic signed [EntryW-1:0] value;  // key compared against each entry
    logic signed [EntryW-1:0] carry;  // entry being pushed down on insert
    logic                     hit;    // insert placed / delete matched upstream
  } pkt_t;

endpackage

@@ rtl/stkl_if.sv @@
// stkl_in_if / stkl_out_if: valid-ready channels carrying input and output beats.
// Depends on stkl_pkg.
`timescale 1ns / 1ps

interface stkl_in_if;
  logic               valid;
  logic               ready;
  stkl_pkg::in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface stkl_out_if;
  logic                valid;
  logic                ready;
  stkl_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/sorted_topk_list_core.sv @@
// sorted_topk_list_core: sorted top-K list built as a chain of slot cells.
// Depends on stkl_pkg, stkl_in_if / stkl_out_if and stkl_cell.
//
//  channel  dir  signals                        beat
//  in_i     in   valid/ready/data (in_beat_t)   func, value
//  out_o    out  valid/ready/data (out_beat_t)  head_entry, tail_entry, delete_found
//  cfg      in   cfg_we_i/cfg_idx_i/cfg_wdata_i register write, no handshake
//
// An accepted beat enters slot 0 at once and moves one slot per cycle; the
// result is loaded into the output register straight from the last slot's
// output, unless an earlier result is still waiting there.
// A new beat is taken as soon as the previous result is in the output register.
// A stalled output holds the result in the core until out_o.ready.
// Reset sets every entry to the most negative value; there is no clearing pass.
`timescale 1ns / 1ps

module sorted_topk_list_core #(
  parameter int unsigned LIST_DEPTH = stkl_pkg::ListDepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [stkl_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [stkl_pkg::CfgDataW-1:0]     cfg_wdata_i,
  stkl_in_if.sink                           in_i,
  stkl_out_if.source                        out_o
);
  import stkl_pkg::*;

  // Configuration registers
  logic                     desc_q;
  logic signed [EntryW-1:0] fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q <= 1'b1;
      fill_q <= EntryMin;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DESCENDING: desc_q <= cfg_wdata_i[0];
        CFG_FILL_VALUE: fill_q <= cfg_wdata_i[EntryW-1:0];
        default: ;
      endcase
    end
  end

  // Slot chain
  pkt_t                     pkt   [LIST_DEPTH+1];
  logic signed [EntryW-1:0] entry [LIST_DEPTH];
  logic                     accept;
  logic                     busy_q;

  assign in_i.ready = !busy_q;
  assign accept     = in_i.valid && !busy_q;

  always_comb begin
    pkt[0].tok   = accept;
    pkt[0].func  = in_i.data.func;
    pkt[0].value = in_i.data.value;
    pkt[0].carry = in_i.data.value;
    pkt[0].hit   = 1'b0;
  end

  for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
    logic signed [EntryW-1:0] nxt;
    if (k == LIST_DEPTH - 1) begin : g_last
      assign nxt = fill_q;
    end else begin : g_mid
      assign nxt = entry[k+1];
    end
    stkl_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .desc_i      (desc_q),
      .pkt_i       (pkt[k]),
      .nxt_entry_i (nxt),
      .pkt_o       (pkt[k+1]),
      .entry_o     (entry[k])
    );
  end

  // Completion and output register
  logic      done_q;
  logic      found_q;
  logic      pend;
  logic      pend_found;
  logic      load;
  logic      out_valid_q;
  out_beat_t out_data_q;

  assign pend       = pkt[LIST_DEPTH].tok || done_q;
  assign pend_found = pkt[LIST_DEPTH].tok
                      ? (pkt[LIST_DEPTH].hit && (pkt[LIST_DEPTH].func == FUNC_DELETE))
                      : found_q;
  assign load       = pend && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      done_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (load) begin
        busy_q <= 1'b0;
      end
      done_q  <= pend && !load;
      found_q <= pend_found;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // entries stay stable while the result waits, so read them at load
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q.head_entry   <= entry[0];
      out_data_q.tail_entry   <= entry[LIST_DEPTH-1];
      out_data_q.delete_found <= pend_found;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

@@ rtl/stkl_cell.sv @@
// stkl_cell: one list slot; applies the passing operation token to its entry
// and hands the token on to the next slot. Depends on stkl_pkg.
`timescale 1ns / 1ps

module stkl_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 desc_i,
  input  stkl_pkg::pkt_t                       pkt_i,
  input  logic signed [stkl_pkg::EntryW-1:0]   nxt_entry_i,
  output stkl_pkg::pkt_t                       pkt_o,
  output logic signed [stkl_pkg::EntryW-1:0]   entry_o
);
  import stkl_pkg::*;

  logic signed [EntryW-1:0] entry_q, entry_d;
  pkt_t                     pkt_q, pkt_d;
  logic                     beats;
  logic                     equal;

  // Ranking and match against the stored entry
  assign beats = desc_i ? (pkt_i.value > entry_q) : (pkt_i.value < entry_q);
  assign equal = (pkt_i.value == entry_q);

  // Slot update and token hand-off
  always_comb begin
    entry_d = entry_q;
    pkt_d   = pkt_i;
    if (pkt_i.tok) begin
      case (pkt_i.func)
        FUNC_INSERT: begin
          if (pkt_i.hit) begin
            entry_d     = pkt_i.carry;
            pkt_d.carry = entry_q;
          end else if (beats) begin
            entry_d     = pkt_i.value;
            pkt_d.carry = entry_q;
            pkt_d.hit   = 1'b1;
          end
        end
        FUNC_DELETE: begin
          // downstream slot is still untouched, so pull it up
          if (pkt_i.hit || equal) begin
            entry_d   = nxt_entry_i;
            pkt_d.hit = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= EntryMin;
      pkt_q   <= '0;
    end else begin
      entry_q <= entry_d;
      pkt_q   <= pkt_d;
    end
  end

  assign pkt_o   = pkt_q;
  assign entry_o = entry_q;

endmodule

@@ sim/sorted_topk_list_core_tb.sv @@
// Self-checking testbench for sorted_topk_list_core: directed and random insert/delete
// beats under both list orders and several fill values, checked against a cycle-free list model.
// Depends on stkl_pkg, stkl_in_if / stkl_out_if and the core RTL.
`timescale 1ns / 1ps

module sorted_topk_list_core_tb;
  import stkl_pkg::*;

  localparam int unsigned LIST_DEPTH = ListDepthDef;
  localparam logic signed [EntryW-1:0] EntryMax = {1'b0, {(EntryW-1){1'b1}}};

  // List model: mirrors the entries and registers, queues the expected beats
  class topk_list_model;
    logic signed [EntryW-1:0] entries [LIST_DEPTH];
    logic                     largest_first;
    logic signed [EntryW-1:0] fill;
    out_beat_t                pending_results [$];
    int                       mismatch_cnt;

    function void clear();
      for (int i = 0; i < LIST_DEPTH; i++) entries[i] = EntryMin;
      largest_first = 1'b1;
      fill = EntryMin;
      pending_results.delete();
      mismatch_cnt = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == CFG_DESCENDING) largest_first = data[0];
      else if (idx == CFG_FILL_VALUE) fill = data;
    endfunction

    function logic outranks(logic signed [EntryW-1:0] v, logic signed [EntryW-1:0] e);
      return largest_first ? (v > e) : (v < e);
    endfunction

    // Apply one accepted beat and queue the beat the core should return
    function void note_op(in_beat_t b);
      logic signed [EntryW-1:0] v;
      int                       pos;
      out_beat_t                r;
      v = b.value;
      pos = LIST_DEPTH;
      r.delete_found = 1'b0;
      if (b.func == FUNC_INSERT) begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
          if (pos == LIST_DEPTH && outranks(v, entries[i])) pos = i;
        end
        if (pos < LIST_DEPTH) begin
          for (int i = LIST_DEPTH - 1; i > pos; i--) entries[i] = entries[i-1];
          entries[pos] = v;
        end
      end else begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
          if (pos == LIST_DEPTH && entries[i] == v) pos = i;
        end
        if (pos < LIST_DEPTH) begin
          for (int i = pos; i < LIST_DEPTH - 1; i++) entries[i] = entries[i+1];
          entries[LIST_DEPTH-1] = fill;
          r.delete_found = 1'b1;
        end
      end
      r.head_entry = entries[0];
      r.tail_entry = entries[LIST_DEPTH-1];
      pending_results.push_back(r);
    endfunction

    function void report_mismatch(string what);
      $display("mismatch: %s", what);
      mismatch_cnt++;
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t exp;
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing outstanding");
        return;
      end
      exp = pending_results.pop_front();
      if (got.head_entry !== exp.head_entry)
        report_mismatch($sformatf("head_entry got %0d exp %0d", got.head_entry,
                                  exp.head_entry));
      if (got.tail_entry !== exp.tail_entry)
        report_mismatch($sformatf("tail_entry got %0d exp %0d", got.tail_entry,
                                  exp.tail_entry));
      if (got.delete_found !== exp.delete_found)
        report_mismatch($sformatf("delete_found got %b exp %b", got.delete_found,
                                  exp.delete_found));
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = CFG_DESCENDING;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  bit                  idle_on = 1'b1;
  bit                  hold_req = 1'b0;
  topk_list_model      model;

  stkl_in_if  in_if ();
  stkl_out_if out_if ();

  sorted_topk_list_core #(.LIST_DEPTH(LIST_DEPTH)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
  end

  // Beat monitor: results first, then the newly accepted operation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) model.check_result(out_if.data);
      if (in_if.valid && in_if.ready) model.note_op(in_if.data);
    end
  end

  // Result sink: random back-pressure bursts, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (300) @(negedge clk_i);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Send one operation beat; entered and left at a falling edge
  task automatic send_op(func_e f, logic signed [EntryW-1:0] v);
    in_beat_t b;
    b.func  = f;
    b.value = v;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop valid and wait for every outstanding result, then let the chain empty
  task automatic settle();
    int waited;
    waited = 0;
    in_if.valid <= 1'b0;
    while (model.pending_results.size() != 0 && waited < 20000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (LIST_DEPTH + 4) @(negedge clk_i);
  endtask

  // Write both registers back to back; core is idle here
  task automatic program_regs(logic desc, logic signed [EntryW-1:0] fill);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_DESCENDING;
    cfg_wdata_i <= {{(CfgDataW-1){1'b0}}, desc};
    model.write_reg(CFG_DESCENDING, {{(CfgDataW-1){1'b0}}, desc});
    @(negedge clk_i);
    cfg_idx_i   <= CFG_FILL_VALUE;
    cfg_wdata_i <= fill;
    model.write_reg(CFG_FILL_VALUE, fill);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Random operations: mostly values near zero or already in the list, so that
  // ties and delete hits are common; the rest is extreme values or full-range noise
  task automatic run_random(int n);
    logic signed [EntryW-1:0] v;
    func_e                    f;
    for (int k = 0; k < n; k++) begin
      f = ($urandom_range(0, 9) < 6) ? FUNC_INSERT : FUNC_DELETE;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: v = $signed($urandom_range(0, 40)) - 20;
        5: begin
          case ($urandom_range(0, 3))
            0: v = EntryMin;
            1: v = EntryMax;
            2: v = -1;
            default: v = 0;
          endcase
        end
        6, 7: v = model.entries[$urandom_range(0, LIST_DEPTH - 1)];
        default: v = $urandom;
      endcase
      send_op(f, v);
    end
  endtask

  // Stimulus and end of run
  initial begin
    model = new();
    model.clear();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset registers, largest first, fill at the minimum
    send_op(FUNC_INSERT, EntryMin);  // ranks with the tail, dropped
    send_op(FUNC_DELETE, 5);         // miss
    send_op(FUNC_INSERT, EntryMax);
    send_op(FUNC_INSERT, 0);
    send_op(FUNC_INSERT, 0);         // tie goes after the equal entry
    send_op(FUNC_INSERT, -1);
    send_op(FUNC_DELETE, 0);
    send_op(FUNC_DELETE, EntryMin);
    send_op(FUNC_DELETE, EntryMax);  // head removed
    for (int i = 0; i < 8; i++) send_op(FUNC_INSERT, i * 3 + 1);
    send_op(FUNC_INSERT, -100);      // list not yet full, lands above the reset entries
    settle();

    // Fill above every entry: out of sort order once a delete frees the tail
    program_regs(1'b1, EntryMax);
    send_op(FUNC_DELETE, 7);
    send_op(FUNC_INSERT, 2);
    send_op(FUNC_INSERT, -5);
    settle();

    // Order flipped with entries present: no re-sort
    program_regs(1'b0, EntryMin);
    send_op(FUNC_INSERT, EntryMin);
    send_op(FUNC_INSERT, 50);
    send_op(FUNC_DELETE, EntryMax);
    send_op(FUNC_DELETE, 1234);
    settle();

    // Random phases over several register settings
    program_regs(1'b1, EntryMin);
    run_random(196);
    settle();

    // Long result hold-off while operations keep coming
    program_regs(1'b0, EntryMax);
    hold_req = 1'b1;
    run_random(196);
    settle();

    program_regs(1'b0, EntryMin);
    run_random(196);
    settle();

    program_regs(1'b1, EntryMax);
    run_random(196);
    settle();

    program_regs(1'b1, $urandom);
    run_random(196);
    settle();

    // Last part: no idling on either side
    program_regs(1'b0, $urandom);
    idle_on = 1'b0;
    run_random(196);
    settle();

    if (model.pending_results.size() != 0)
      model.report_mismatch($sformatf("%0d results never arrived",
                                      model.pending_results.size()));
    if (model.mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
